// File: rtl/assert_macros.svh
// Assertion macros for the RTL. They compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every rising clock edge outside reset.
`define SIRC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define SIRC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SIRC_ASSERT(label, clk, rst, prop, msg)
`define SIRC_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: rtl/sirc_pkg.sv
`default_nettype none

package sirc_pkg;

  localparam int VALUE_BITS    = 32;
  localparam int MAX_ALPHABET  = 16;
  localparam int SIZE_W        = 5;
  localparam int CHAR_W        = 8;
  localparam int CHAR_IDX_W    = 4;
  localparam int NUM_CHARS     = 16;
  localparam int REM_W         = (MAX_ALPHABET > 2) ? $clog2(MAX_ALPHABET) : 1;
  localparam int COUNT_W       = $clog2(VALUE_BITS + 1);
  localparam int IDX_W         = $clog2(VALUE_BITS);
  localparam int DIV_STEP_BITS = 8;
  localparam int DIV_STEPS     = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int WORK_W        = DIV_STEPS * DIV_STEP_BITS;
  localparam int DIV_CNT_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 64;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [SIZE_W-1:0] MIN_RADIX  = 5'd2;

  localparam logic [SIZE_W-1:0]     RST_ALPHABET_SIZE = 5'd10;
  localparam logic [CFG_DATA_W-1:0] RST_CHARS_LOW     = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] RST_CHARS_HIGH    = 64'h0000_0000_0000_3938;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH    = 2'd2;

  typedef logic [2*CFG_DATA_W-1:0] chars_t;

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [SIZE_W-1:0]     radix;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [REM_W-1:0]      remainder;
  } div_rsp_t;

  function automatic logic [CHAR_W-1:0] char_at(input chars_t chars,
                                                input logic [CHAR_IDX_W-1:0] idx);
    char_at = chars[idx*CHAR_W +: CHAR_W];
  endfunction

endpackage

`default_nettype wire

// File: rtl/signed_int_to_radix_chars.sv
// Channel  | Direction | Payload
// s_*      | in        | tdata[31:0] value (signed)
// m_*      | out       | tdata[7:0] character, tlast = last
// cfg_*    | in        | cfg_index register, cfg_data write data
//
// An accepted value is divided digit by digit in the divider, eight bits per step,
// and then the characters are sent out one by one.
// Up to 32 digits plus a sign make a run of up to 33 characters.
// The block takes no new value until its last character is in the output register.
// A stalled output holds the sequencer; reset is synchronous and clears all control.
`default_nettype none

module signed_int_to_radix_chars
  import sirc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [VALUE_BITS-1:0] s_tdata,   // [31:0] value
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [CHAR_W-1:0]          m_tdata,   // [7:0] character
  output logic                       m_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SIGN, ST_EMIT} state_t;

  state_t                 state;
  logic [SIZE_W-1:0]      alphabet_size;
  logic [CFG_DATA_W-1:0]  chars_low;
  logic [CFG_DATA_W-1:0]  chars_high;
  chars_t                 chars;
  logic                   alpha_ok;
  logic                   neg;
  logic [COUNT_W-1:0]     count;
  logic [COUNT_W-1:0]     count_m1;
  logic [REM_W-1:0]       digit_store [VALUE_BITS];
  logic                   in_xfer;
  logic                   out_free;
  logic                   out_load;
  logic                   in_neg;
  logic [VALUE_BITS-1:0]  in_mag;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  assign chars     = {chars_high, chars_low};
  assign cfg_ready = 1'b1;
  assign s_tready  = state == ST_IDLE;
  assign in_xfer   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = out_free && (state == ST_SIGN || state == ST_EMIT);
  assign count_m1  = count - 1'b1;
  assign in_neg    = s_tdata[VALUE_BITS-1];
  assign in_mag    = in_neg ? (~s_tdata + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : s_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_size <= RST_ALPHABET_SIZE;
      chars_low     <= RST_CHARS_LOW;
      chars_high    <= RST_CHARS_HIGH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ALPHABET_SIZE: alphabet_size <= cfg_data[SIZE_W-1:0];
        REG_CHARS_LOW:     chars_low     <= cfg_data;
        REG_CHARS_HIGH:    chars_high    <= cfg_data;
        default: ;
      endcase
    end
  end

  sirc_alpha_check u_alpha (
    .alphabet_size (alphabet_size),
    .chars         (chars),
    .ok            (alpha_ok)
  );

  always_comb begin
    div_req.radix    = alphabet_size;
    div_req.start    = 1'b0;
    div_req.dividend = in_mag;
    if (state == ST_IDLE) begin
      div_req.start = in_xfer && alpha_ok;
    end else if (state == ST_DIV) begin
      div_req.start    = div_rsp.done && div_rsp.quotient != '0;
      div_req.dividend = div_rsp.quotient;
    end
  end

  sirc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (state == ST_DIV && div_rsp.done) begin
      digit_store[count[IDX_W-1:0]] <= div_rsp.remainder;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      neg      <= 1'b0;
      count    <= '0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
      m_tlast  <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer && alpha_ok) begin
            neg   <= in_neg;
            count <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            count <= count + 1'b1;
            if (div_rsp.quotient == '0) begin
              state <= neg ? ST_SIGN : ST_EMIT;
            end
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            m_tdata  <= CHAR_MINUS;
            m_tlast  <= 1'b0;
            state    <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tdata  <= char_at(chars, CHAR_IDX_W'(digit_store[count_m1[IDX_W-1:0]]));
            m_tlast  <= count == COUNT_W'(1);
            count    <= count_m1;
            if (count == COUNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SIRC_ASSERT(a_count_bound, clk, rst, count <= COUNT_W'(VALUE_BITS), "digit count overflow")
  `SIRC_ASSERT(a_emit_nonempty, clk, rst, state == ST_EMIT |-> count != '0, "emit with no digits")
  `SIRC_ASSERT(a_div_owner, clk, rst, div_rsp.done |-> state == ST_DIV, "divider done outside division")
  `SIRC_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> state == ST_IDLE && !m_tvalid, "reset not clearing")

endmodule

`default_nettype wire

// File: rtl/sirc_alpha_check.sv
`default_nettype none

module sirc_alpha_check
  import sirc_pkg::*;
(
  input  wire logic [SIZE_W-1:0] alphabet_size,
  input  wire chars_t            chars,
  output logic                   ok
);

  logic [NUM_CHARS-1:0] in_use;
  logic                 bad;

  always_comb begin
    for (int i = 0; i < NUM_CHARS; i++) begin
      in_use[i] = SIZE_W'(i) < alphabet_size;
    end
  end

  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < NUM_CHARS; i++) begin
      if (in_use[i] && (char_at(chars, CHAR_IDX_W'(i)) == CHAR_PLUS ||
                        char_at(chars, CHAR_IDX_W'(i)) == CHAR_MINUS)) begin
        bad = 1'b1;
      end
      for (int j = i + 1; j < NUM_CHARS; j++) begin
        if (in_use[j] && char_at(chars, CHAR_IDX_W'(i)) == char_at(chars, CHAR_IDX_W'(j))) begin
          bad = 1'b1;
        end
      end
    end
  end

  assign ok = !bad && alphabet_size >= MIN_RADIX &&
              alphabet_size <= SIZE_W'(MAX_ALPHABET);

endmodule

`default_nettype wire

// File: rtl/sirc_div.sv
`default_nettype none

module sirc_div
  import sirc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [WORK_W-1:0]    work;
  logic [REM_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 running;
  logic                 done;
  logic [WORK_W-1:0]    work_next;
  logic [REM_W-1:0]     rem_next;
  logic [SIZE_W-1:0]    trial;

  // Long division, several dividend bits per cycle; the partial
  // remainder always stays below a nonzero radix.
  always_comb begin
    work_next = work;
    rem_next  = rem;
    trial     = '0;
    for (int b = 0; b < DIV_STEP_BITS; b++) begin
      trial     = SIZE_W'({rem_next, work_next[WORK_W-1]});
      work_next = {work_next[WORK_W-2:0], 1'b0};
      if (trial >= req.radix) begin
        rem_next     = REM_W'(trial - req.radix);
        work_next[0] = 1'b1;
      end else begin
        rem_next = REM_W'(trial);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      work <= WORK_W'(req.dividend);
      rem  <= '0;
    end else if (running) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = work[VALUE_BITS-1:0];
  assign rsp.remainder = rem;

endmodule

`default_nettype wire
